[hw/rtl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg
// shared constants, tables and byte-level round functions for the aes block
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int KEY_ROWS   = 15;                // round key rows, 14 rounds + 1
    localparam int ROW_AW     = $clog2(KEY_ROWS);
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE   = 3'd4;

    // key size codes
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;
    typedef logic [7:0]   byte_t;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic byte_t rcon(input logic [3:0] j);
        byte_t r;
        unique case (j)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h01;
        endcase
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic word_t mix_word(input word_t w);
        byte_t a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic word_t inv_mix_word(input word_t w);
        byte_t a [4];
        byte_t m9 [4];
        byte_t m11 [4];
        byte_t m13 [4];
        byte_t m14 [4];
        byte_t x2, x4, x8;
        for (int k = 0; k < 4; k++)
        begin
            a[k]   = w[31-8*k -: 8];
            x2     = xtime(a[k]);
            x4     = xtime(x2);
            x8     = xtime(x4);
            m9[k]  = x8 ^ a[k];
            m11[k] = x8 ^ x2 ^ a[k];
            m13[k] = x8 ^ x4 ^ a[k];
            m14[k] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
    endfunction

    // byte n of a block, byte 0 in the top bits
    function automatic byte_t get_byte(input block_t s, input int n);
        return s[127-8*n -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        return t;
    endfunction

    function automatic block_t inv_sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[get_byte(s, 4*c+r)];
            end
        end
        return t;
    endfunction

endpackage

[hw/rtl/aes_ram.sv]
// ----------------------------------------------------------------------------
// aes_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/aes_round.sv]
// ----------------------------------------------------------------------------
// aes_round
// one cipher round, forward or equivalent inverse, with key addition
// ----------------------------------------------------------------------------
module aes_round (
    input  aes_pkg::block_t state_in,
    input  aes_pkg::block_t round_key,
    input  logic            decrypt,
    input  logic            final_round,
    output aes_pkg::block_t state_out
);

    aes_pkg::block_t subbed;
    aes_pkg::block_t mixed;

    always_comb
    begin
        subbed = decrypt ? aes_pkg::inv_sub_shift(state_in) : aes_pkg::sub_shift(state_in);
        for (int c = 0; c < 4; c++)
        begin
            mixed[127-32*c -: 32] = decrypt ? aes_pkg::inv_mix_word(subbed[127-32*c -: 32])
                                            : aes_pkg::mix_word(subbed[127-32*c -: 32]);
        end
        state_out = (final_round ? subbed : mixed) ^ round_key;
    end

endmodule

[hw/rtl/aes_block_cipher.sv]
// ----------------------------------------------------------------------------
// aes_block_cipher
// aes-128/192/256 encrypt and decrypt, one round per cycle, keys held in ram
// ----------------------------------------------------------------------------
// Any write to a key register or to key_size starts a key expansion that
// produces one 32-bit key word per cycle, 44, 52 or 60 words in all for
// 128-, 192- and 256-bit keys; in_ready stays low until it finishes. Each
// 128-bit row of round keys goes to a forward ram, and the same row passed
// through InvMixColumns (first and last rows copied) goes to an inverse ram.
// A block then goes through an initial key addition, Nr rounds through the
// shared round unit with one round key row read from ram per cycle, and a
// final step that moves the result to the output register. The output
// register lets the next beat be accepted while a result still waits; a
// finished block holds in the core only if the previous result has not yet
// been taken. Blocks sent before any key write give unspecified results.
// ----------------------------------------------------------------------------
module aes_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_KEY0  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // key registers
    logic [63:0] key_word_reg [4];
    logic [1:0]  key_size_reg;

    // expansion sequencer
    logic        exp_reg;
    logic [5:0]  widx_reg;        // word index within the schedule
    logic [2:0]  wmod_reg;        // word index modulo nk
    logic [3:0]  rci_reg;         // rcon index
    logic [2:0]  nkm1_reg;        // nk - 1
    logic [3:0]  nr_reg;          // rounds
    aes_pkg::word_t win_reg [8];  // last eight key words, newest first
    logic [95:0] rowbuf_reg;

    // cipher sequencer
    logic [1:0]              st_reg;
    logic                    dec_reg;
    logic [3:0]              rnd_reg;
    logic [3:0]              addr_reg;
    aes_pkg::block_t         state_reg;
    logic                    out_valid_reg;
    aes_pkg::block_t         out_reg;

    logic                    cfg_hit;
    logic [1:0]              ks_new;
    logic [2:0]              nkm1_new;
    logic                    in_accept;
    logic                    out_free;
    logic                    last_round;

    aes_pkg::word_t          kword;
    aes_pkg::word_t          tword;
    aes_pkg::word_t          nword;
    aes_pkg::block_t         row_data;
    aes_pkg::block_t         inv_row;
    logic                    row_we;
    logic                    row_edge;
    logic [3:0]              rd_addr;
    aes_pkg::block_t         fwd_key;
    aes_pkg::block_t         inv_key;
    aes_pkg::block_t         cur_key;
    aes_pkg::block_t         round_out;

    assign cfg_hit   = cfg_write && (cfg_index <= aes_pkg::CFG_KEY_SIZE);
    assign ks_new    = (cfg_index == aes_pkg::CFG_KEY_SIZE) ? cfg_data[1:0] : key_size_reg;
    assign nkm1_new  = (ks_new == aes_pkg::KS_128) ? 3'd3 :
                       (ks_new == aes_pkg::KS_192) ? 3'd5 : 3'd7;

    assign in_ready   = (st_reg == ST_IDLE) && !exp_reg;
    assign in_accept  = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign last_round = (rnd_reg == nr_reg);

    // next key word of the schedule
    always_comb
    begin
        kword = widx_reg[0] ? key_word_reg[widx_reg[2:1]][31:0]
                            : key_word_reg[widx_reg[2:1]][63:32];
        tword = win_reg[0];
        if (wmod_reg == 3'd0)
        begin
            tword = aes_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                  ^ {aes_pkg::rcon(rci_reg), 24'h0};
        end
        else if ((nkm1_reg == 3'd7) && (wmod_reg == 3'd4))
        begin
            tword = aes_pkg::sub_word(win_reg[0]);
        end
        nword = (widx_reg <= {3'b000, nkm1_reg}) ? kword : (win_reg[nkm1_reg] ^ tword);
    end

    // a full row every fourth word; middle rows also go out inverse-mixed
    assign row_data = {rowbuf_reg, nword};
    assign row_we   = exp_reg && (widx_reg[1:0] == 2'b11);
    assign row_edge = (widx_reg[5:2] == 4'd0) || (widx_reg[5:2] == nr_reg);

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            inv_row[127-32*c -: 32] = row_edge ? row_data[127-32*c -: 32]
                                               : aes_pkg::inv_mix_word(row_data[127-32*c -: 32]);
        end
    end

    // first key row comes from the beat's opcode, later rows from the counter
    assign rd_addr = in_accept ? (opcode ? nr_reg : 4'd0) : addr_reg;

    aes_ram #(
        .WIDTH (128),
        .DEPTH (aes_pkg::KEY_ROWS)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (widx_reg[5:2]),
        .wdata (row_data),
        .raddr (rd_addr),
        .rdata (fwd_key)
    );

    aes_ram #(
        .WIDTH (128),
        .DEPTH (aes_pkg::KEY_ROWS)
    ) u_inv_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (widx_reg[5:2]),
        .wdata (inv_row),
        .raddr (rd_addr),
        .rdata (inv_key)
    );

    assign cur_key = dec_reg ? inv_key : fwd_key;

    aes_round u_round (
        .state_in    (state_reg),
        .round_key   (cur_key),
        .decrypt     (dec_reg),
        .final_round (last_round),
        .state_out   (round_out)
    );

    // key registers and expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                key_word_reg[k] <= '0;
            end
            key_size_reg <= aes_pkg::KS_128;
            exp_reg      <= 1'b0;
            widx_reg     <= '0;
            wmod_reg     <= '0;
            rci_reg      <= '0;
            nkm1_reg     <= 3'd3;
            nr_reg       <= 4'd10;
        end
        else
        begin
            if (cfg_hit)
            begin
                if (cfg_index == aes_pkg::CFG_KEY_SIZE)
                begin
                    key_size_reg <= cfg_data[1:0];
                end
                else
                begin
                    key_word_reg[cfg_index[1:0]] <= cfg_data;
                end
                // restart from the first word with the new key length
                exp_reg  <= 1'b1;
                widx_reg <= '0;
                wmod_reg <= '0;
                rci_reg  <= '0;
                nkm1_reg <= nkm1_new;
                nr_reg   <= {1'b0, nkm1_new} + 4'd7;
            end
            else if (exp_reg)
            begin
                if ((widx_reg[5:2] == nr_reg) && (widx_reg[1:0] == 2'b11))
                begin
                    exp_reg <= 1'b0;
                end
                widx_reg <= widx_reg + 6'd1;
                wmod_reg <= (wmod_reg == nkm1_reg) ? 3'd0 : wmod_reg + 3'd1;
                if ((wmod_reg == 3'd0) && (widx_reg > {3'b000, nkm1_reg}))
                begin
                    rci_reg <= rci_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_reg)
        begin
            win_reg[0] <= nword;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            rowbuf_reg <= row_data[95:0];
        end
    end

    // cipher control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rnd_reg       <= '0;
            addr_reg      <= '0;
            dec_reg       <= 1'b0;
        end
        else
        begin
            // a finished block loads the output register once it is free
            if ((st_reg == ST_FLUSH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        dec_reg  <= opcode;
                        addr_reg <= opcode ? nr_reg - 4'd1 : 4'd1;
                        st_reg   <= ST_KEY0;
                    end
                end
                ST_KEY0:
                begin
                    rnd_reg  <= 4'd1;
                    addr_reg <= dec_reg ? addr_reg - 4'd1 : addr_reg + 4'd1;
                    st_reg   <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    rnd_reg  <= rnd_reg + 4'd1;
                    addr_reg <= dec_reg ? addr_reg - 4'd1 : addr_reg + 4'd1;
                    if (last_round)
                    begin
                        st_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // block datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            state_reg <= {block_hi, block_lo};
        end
        else if (st_reg == ST_KEY0)
        begin
            state_reg <= state_reg ^ cur_key;
        end
        else if (st_reg == ST_ROUND)
        begin
            state_reg <= round_out;
        end
        if ((st_reg == ST_FLUSH) && out_free)
        begin
            out_reg <= state_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_hi = out_reg[127:64];
    assign result_lo = out_reg[63:0];

endmodule

[hw/rtl/aes_checker.sv]
// ----------------------------------------------------------------------------
// aes_checker
// port-level checks on the aes block, bound to the top level
// ----------------------------------------------------------------------------
module aes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic [2:0]  cfg_index,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_hi,
    input logic [63:0] result_lo
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_hi) && $stable(result_lo))
        else $error("stalled result changed");

    // one block at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("beat accepted while busy");

    // key expansion holds off input
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index <= aes_pkg::CFG_KEY_SIZE) |=> !in_ready)
        else $error("input open during key expansion");

    // a new result only follows a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

endmodule

bind aes_block_cipher aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_hi (result_hi),
    .result_lo (result_lo)
);
